// ===== sv/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    localparam logic signed [VAL_W-1:0] NOT_FOUND_VALUE = '1;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    typedef struct packed {
        logic valid;
        logic shift;
    } t_cell_ctrl;

endpackage

// ===== sv/lkvc_cell.sv =====
// ----------------------------------------------------------------------------
// lkvc_cell
// One recency position: holds a key-value pair, compares it against the
// lookup key, and takes its neighbor's pair when the order shifts.
// ----------------------------------------------------------------------------
module lkvc_cell (
    input  logic                                   i_clk,
    input  lkvc_pkg::t_cell_ctrl                   i_ctrl,
    input  logic signed [lkvc_pkg::KEY_W-1:0]      i_cmp_key,
    input  logic signed [lkvc_pkg::KEY_W-1:0]      i_prev_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0]      i_prev_value,
    output logic signed [lkvc_pkg::KEY_W-1:0]      o_key,
    output logic signed [lkvc_pkg::VAL_W-1:0]      o_value,
    output logic signed [lkvc_pkg::VAL_W-1:0]      o_match_value,
    output logic                                   o_match
);
    import lkvc_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

    assign o_key         = r_key;
    assign o_value       = r_value;
    assign o_match       = i_ctrl.valid && (r_key == i_cmp_key);
    assign o_match_value = o_match ? r_value : '0;

endmodule

// ===== sv/lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value store with least-recently-used replacement.
//
// The input channel carries a kind (get or put), a key and a value. On
// acceptance every cell compares its key with the incoming key and the hits
// are registered; in the update state that follows, the row of cells shifts
// toward the least recent end so that the touched or inserted pair lands in
// cell 0. The input stalls until the update is done. A get produces one
// output transaction (found flag and value, or -1 on a miss) in the output
// register when its update completes; a put produces none. The output
// register lets the next transaction be accepted while a result waits; if a
// result is still stalled when the next get finishes its compare, that get
// holds its update cycle until the register frees up. Synchronous reset
// empties the store and sets the capacity to 16. The user must write the
// capacity register (i_cfg_we, i_cfg_wdata) only while idle (unenforced).
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]             i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_kind,
    input  logic signed [lkvc_pkg::KEY_W-1:0]      i_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0]      i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_found,
    output logic signed [lkvc_pkg::VAL_W-1:0]      o_read_value
);
    import lkvc_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    t_state                  r_state;
    logic [CAP_W-1:0]        r_capacity;
    logic [CNT_W-1:0]        r_count;
    logic                    r_kind;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;
    logic [MAX_ENTRIES-1:0]  r_hit;
    logic signed [VAL_W-1:0] r_hit_value;
    logic                    r_out_valid;
    logic                    r_found;
    logic signed [VAL_W-1:0] r_read_value;

    logic signed [KEY_W-1:0] w_key   [MAX_ENTRIES];
    logic signed [VAL_W-1:0] w_val   [MAX_ENTRIES];
    logic signed [VAL_W-1:0] w_mval  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  w_match;
    t_cell_ctrl              w_ctrl  [MAX_ENTRIES];
    logic signed [VAL_W-1:0] w_match_or;
    logic [CNT_W-1:0]        w_eff_cap;
    logic                    w_full;
    logic                    w_any_hit;
    logic                    w_in_acc;
    logic                    w_upd_go;
    logic signed [VAL_W-1:0] w_front_value;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_any_hit  = |r_hit;
    assign w_upd_go   = (r_state == S_UPD) &&
                        !((r_kind == KIND_GET) && r_out_valid && i_out_stall);

    always_comb begin
        if (r_capacity == '0) begin
            w_eff_cap = CNT_W'(1);
        end else if (int'(r_capacity) > MAX_ENTRIES) begin
            w_eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            w_eff_cap = CNT_W'(r_capacity);
        end
    end

    assign w_full        = (r_count >= w_eff_cap);
    assign w_front_value = (r_kind == KIND_PUT) ? r_value : r_hit_value;

    always_comb begin
        w_match_or = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_match_or = w_match_or | w_mval[i];
        end
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic                    w_shift;
        logic signed [KEY_W-1:0] w_prev_key;
        logic signed [VAL_W-1:0] w_prev_val;

        always_comb begin
            if (w_any_hit) begin
                w_shift = |(r_hit >> g);
            end else if (r_kind == KIND_PUT) begin
                w_shift = w_full ? (CNT_W'(g) < r_count) : (CNT_W'(g) <= r_count);
            end else begin
                w_shift = 1'b0;
            end
        end

        assign w_ctrl[g].valid = (CNT_W'(g) < r_count);
        assign w_ctrl[g].shift = w_upd_go && w_shift;

        if (g == 0) begin : g_head
            assign w_prev_key = r_key;
            assign w_prev_val = w_front_value;
        end else begin : g_body
            assign w_prev_key = w_key[g-1];
            assign w_prev_val = w_val[g-1];
        end

        lkvc_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl[g]),
            .i_cmp_key     (i_key),
            .i_prev_key    (w_prev_key),
            .i_prev_value  (w_prev_val),
            .o_key         (w_key[g]),
            .o_value       (w_val[g]),
            .o_match_value (w_mval[g]),
            .o_match       (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= CAPACITY_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (w_upd_go && (r_kind == KIND_GET)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_upd_go) begin
                        r_state <= S_IDLE;
                        if ((r_kind == KIND_PUT) && !w_any_hit && !w_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind      <= i_kind;
            r_key       <= i_key;
            r_value     <= i_value;
            r_hit       <= w_match;
            r_hit_value <= w_match_or;
        end
        if (w_upd_go && (r_kind == KIND_GET)) begin
            r_found      <= w_any_hit;
            r_read_value <= w_any_hit ? r_hit_value : NOT_FOUND_VALUE;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_read_value = r_read_value;

    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(r_hit))
        else $error("more than one cell matched the key");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("entry count changed by other than one");

    a_result_from_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_kind) == KIND_GET))
        else $error("a result was produced by a put");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) && w_upd_go && (r_kind == KIND_PUT) && !w_any_hit
            |=> (int'(r_count) <= MAX_ENTRIES))
        else $error("entry count exceeded the store size");

endmodule
